// ===== src/integer_to_ascii_formatter_macros.svh =====
// Assertion helpers used by the top-level formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2A_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2A_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/i2a_pkg.sv =====
package i2a_pkg;

    localparam int MAX_CHARS_DEF  = 64;
    localparam int VALUE_BITS_DEF = 64;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LO    = 8'h6F;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;

    typedef enum logic [1:0] {
        RADIX_BIN = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_DEC = 2'd2,
        RADIX_HEX = 2'd3
    } t_radix;

    typedef struct packed {
        logic       neg;
        t_radix     radix;
        logic [6:0] width;
        logic       zp;
        logic       la;
        logic       ps;
        logic       ss;
        logic       ap;
        logic       uc;
    } t_fmt;

    typedef struct packed {
        logic load;
        logic shift;
    } t_dg_cmd;

    typedef struct packed {
        logic       ready;
        logic [3:0] top;
        logic [3:0] second;
    } t_dg_stat;

    typedef struct packed {
        logic       valid;
        logic [7:0] code;
        logic       last;
    } t_char;

    typedef enum logic [1:0] {
        DG_IDLE,
        DG_DABBLE,
        DG_NORM,
        DG_READY
    } t_dg_state;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_WAIT,
        SQ_SIZE,
        SQ_TRIM,
        SQ_LEAD,
        SQ_SIGN,
        SQ_PFX0,
        SQ_PFX1,
        SQ_ZERO,
        SQ_DIGIT,
        SQ_TRAIL
    } t_sq_state;

    // Decimal digits of the largest vb-bit value (floor(vb*log10(2)) + 1).
    function automatic int dec_digits(input int vb);
        return ((vb * 1233) >> 12) + 1;
    endfunction

    // Digit word width: holds the value or its BCD form, a multiple of 1, 3 and 4.
    function automatic int dig_word_bits(input int vb);
        int wb;
        wb = (vb > 4 * dec_digits(vb)) ? vb : 4 * dec_digits(vb);
        return ((wb + 11) / 12) * 12;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic uc);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else begin
            c = (uc ? CH_UA : CH_LA) + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// ===== src/integer_to_ascii_formatter.sv =====
// Channel   Dir  Handshake               Payload
// s         in   i_s_tvalid/o_s_tready   i_s_tdata (formatting request), i_s_tuser (radix)
// m         out  o_m_tvalid/i_m_tready   o_m_tdata (ASCII char), o_m_tlast (final char)
//
// One number at a time. Decimal values first pass through shift-add-3 conversion; in all
// bases leading zero digits are then dropped (up to the digit-word width in binary), the
// field is laid out, and then the output characters are emitted in order.
// Synchronous active-low reset returns both controllers to idle and empties the output.
// A stalled output holds its character; o_s_tready stays low until the last character of
// the current number has entered the output register.
module integer_to_ascii_formatter
    import i2a_pkg::*;
#(
    parameter int MAX_CHARS  = MAX_CHARS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [63:0] magnitude, [64] is_negative, [71:65] field_width, [72] zero_pad,
    // [73] left_align, [74] plus_sign, [75] space_sign, [76] alt_prefix,
    // [77] upper_case, [79:78] zero
    input  logic [79:0] i_s_tdata,
    // [1:0] radix_select
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] char_code
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast
);

    `include "integer_to_ascii_formatter_macros.svh"

    localparam int CW = $clog2(dig_word_bits(VALUE_BITS) + 1);

    t_fmt          s_fmt;
    t_dg_cmd       s_dg_cmd;
    t_dg_stat      s_dg_stat;
    t_char         s_char;
    logic [CW-1:0] s_dlen;
    logic          s_busy, s_accept, s_out_free;

    logic          r_m_valid;
    logic [7:0]    r_m_data;
    logic          r_m_last;

    always_comb begin
        s_fmt.neg   = i_s_tdata[64];
        s_fmt.radix = t_radix'(i_s_tuser);
        s_fmt.width = i_s_tdata[71:65];
        s_fmt.zp    = i_s_tdata[72];
        s_fmt.la    = i_s_tdata[73];
        s_fmt.ps    = i_s_tdata[74];
        s_fmt.ss    = i_s_tdata[75];
        s_fmt.ap    = i_s_tdata[76];
        s_fmt.uc    = i_s_tdata[77];
        s_accept    = i_s_tvalid && !s_busy;
        s_out_free  = !r_m_valid || i_m_tready;
    end

    i2a_digit_gen #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_CHARS  (MAX_CHARS)
    ) u_digit_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (s_dg_cmd),
        .i_mag   (i_s_tdata[VALUE_BITS-1:0]),
        .i_radix (s_fmt.radix),
        .o_stat  (s_dg_stat),
        .o_dlen  (s_dlen)
    );

    i2a_sequencer #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_CHARS  (MAX_CHARS)
    ) u_sequencer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_accept),
        .i_fmt      (s_fmt),
        .i_stat     (s_dg_stat),
        .i_dlen     (s_dlen),
        .i_out_free (s_out_free),
        .o_cmd      (s_dg_cmd),
        .o_char     (s_char),
        .o_busy     (s_busy)
    );

    // Output register: load a new char or drop the one just taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_char.valid) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
        if (s_char.valid) begin
            r_m_data <= s_char.code;
            r_m_last <= s_char.last;
        end
    end

    assign o_s_tready = !s_busy;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

    `I2A_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready, "accepted item did not make the block busy")
    `I2A_ASSERT_NEXT(a_digits_restart, i_s_tvalid && o_s_tready, !s_dg_stat.ready, "digit unit still ready after a new load")
    `I2A_ASSERT_SAME(a_char_only_busy, s_char.valid, !o_s_tready, "character produced while idle")

endmodule

// ===== src/i2a_digit_gen.sv =====
module i2a_digit_gen
    import i2a_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_CHARS  = MAX_CHARS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dg_cmd                 i_cmd,
    input  logic [VALUE_BITS-1:0]   i_mag,
    input  t_radix                  i_radix,
    output t_dg_stat                o_stat,
    output logic [$clog2(dig_word_bits(VALUE_BITS)+1)-1:0] o_dlen
);

    localparam int DD  = dec_digits(VALUE_BITS);
    localparam int DW  = dig_word_bits(VALUE_BITS);
    localparam int CW  = $clog2(DW + 1);
    localparam int VCW = $clog2(VALUE_BITS + 1);
    localparam logic [CW-1:0] N_BIN = CW'(DW);
    localparam logic [CW-1:0] N_OCT = CW'(DW / 3);
    localparam logic [CW-1:0] N_HEX = CW'(DW / 4);

    t_dg_state             r_state, n_state;
    logic [DW-1:0]         r_word, n_word;
    logic [VALUE_BITS-1:0] r_bin, n_bin;
    t_radix                r_radix, n_radix;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [VCW-1:0]        r_vcnt, n_vcnt;

    logic [7:0]    c_top8;
    logic [3:0]    c_top, c_second;
    logic [DW-1:0] c_adj, c_shift;
    logic          c_norm_step;

    // Top two digits and a one-digit left shift for the current base.
    always_comb begin
        c_top8 = r_word[DW-1 -: 8];
        unique case (r_radix)
            RADIX_BIN: begin
                c_top    = {3'd0, c_top8[7]};
                c_second = {3'd0, c_top8[6]};
                c_shift  = {r_word[DW-2:0], 1'b0};
            end
            RADIX_OCT: begin
                c_top    = {1'b0, c_top8[7:5]};
                c_second = {1'b0, c_top8[4:2]};
                c_shift  = {r_word[DW-4:0], 3'd0};
            end
            RADIX_DEC, RADIX_HEX: begin
                c_top    = c_top8[7:4];
                c_second = c_top8[3:0];
                c_shift  = {r_word[DW-5:0], 4'd0};
            end
        endcase
    end

    // Shift-add-3 correction on every BCD digit.
    always_comb begin
        c_adj = r_word;
        for (int k = 0; k < DD; k++) begin
            if (r_word[4*k +: 4] >= 4'd5) begin
                c_adj[4*k +: 4] = r_word[4*k +: 4] + 4'd3;
            end
        end
    end

    // Drop leading zero digits, and digits beyond the field cap.
    assign c_norm_step = (int'(r_cnt) > MAX_CHARS) || (r_cnt > CW'(1) && c_top == 4'd0);

    always_comb begin
        n_state = r_state;
        if (i_cmd.load) begin
            n_state = (i_radix == RADIX_DEC) ? DG_DABBLE : DG_NORM;
        end else begin
            unique case (r_state)
                DG_IDLE:   n_state = DG_IDLE;
                DG_DABBLE: if (r_vcnt == VCW'(1)) n_state = DG_NORM;
                DG_NORM:   if (!c_norm_step) n_state = DG_READY;
                DG_READY:  n_state = DG_READY;
            endcase
        end
    end

    always_comb begin
        n_word  = r_word;
        n_bin   = r_bin;
        n_radix = r_radix;
        n_cnt   = r_cnt;
        n_vcnt  = r_vcnt;
        if (i_cmd.load) begin
            n_radix = i_radix;
            n_bin   = i_mag;
            n_vcnt  = VCW'(VALUE_BITS);
            n_word  = (i_radix == RADIX_DEC) ? '0 : DW'(i_mag);
            unique case (i_radix)
                RADIX_BIN:            n_cnt = N_BIN;
                RADIX_OCT:            n_cnt = N_OCT;
                RADIX_DEC, RADIX_HEX: n_cnt = N_HEX;
            endcase
        end else begin
            unique case (r_state)
                DG_IDLE: begin
                end
                DG_DABBLE: begin
                    n_word = {c_adj[DW-2:0], r_bin[VALUE_BITS-1]};
                    n_bin  = {r_bin[VALUE_BITS-2:0], 1'b0};
                    n_vcnt = r_vcnt - VCW'(1);
                end
                DG_NORM: begin
                    if (c_norm_step) begin
                        n_word = c_shift;
                        n_cnt  = r_cnt - CW'(1);
                    end
                end
                DG_READY: begin
                    if (i_cmd.shift) n_word = c_shift;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DG_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_word  <= n_word;
        r_bin   <= n_bin;
        r_radix <= n_radix;
        r_cnt   <= n_cnt;
        r_vcnt  <= n_vcnt;
    end

    always_comb begin
        o_stat.ready  = (r_state == DG_READY);
        o_stat.top    = c_top;
        o_stat.second = c_second;
        o_dlen        = r_cnt;
    end

endmodule

// ===== src/i2a_sequencer.sv =====
module i2a_sequencer
    import i2a_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_CHARS  = MAX_CHARS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_fmt     i_fmt,
    input  t_dg_stat i_stat,
    input  logic [$clog2(dig_word_bits(VALUE_BITS)+1)-1:0] i_dlen,
    input  logic     i_out_free,
    output t_dg_cmd  o_cmd,
    output t_char    o_char,
    output logic     o_busy
);

    localparam int LW = ($clog2(MAX_CHARS + 2) > 7) ? $clog2(MAX_CHARS + 2) : 7;
    localparam logic [LW-1:0] L_MAX = LW'(MAX_CHARS);
    localparam logic [LW-1:0] L_ONE = LW'(1);
    localparam logic [LW-1:0] L_TWO = LW'(2);

    t_sq_state     r_state, n_state;
    t_fmt          r_fmt;
    logic          r_apx, r_pfx, r_sgn;
    logic [1:0]    r_skip;
    logic [LW-1:0] r_z, r_dlen, r_len, r_ls, r_ts, r_remain;

    logic [LW-1:0] c_width, c_wp, c_wpm, c_dl, c_z, c_len1, c_wm;
    logic [LW-1:0] c_len3, c_len4, c_pad, c_ls, c_ts;
    logic [LW:0]   c_len_p1;
    logic          c_signf, c_zpm, c_apx, c_topz, c_secz, c_drop, c_pfx, c_sgn;
    logic          c_emit;
    t_sq_state     c_after_digit, c_after_zero, c_after_pfx1, c_after_sign;
    t_sq_state     c_after_lead, c_after_trim;

    // Field layout: zero pad, prefix room, prefix, sign and space padding.
    always_comb begin
        c_width  = LW'(r_fmt.width);
        c_signf  = r_fmt.neg | r_fmt.ps | r_fmt.ss;
        c_zpm    = !r_fmt.la && r_fmt.zp;
        c_wp     = (c_zpm && c_width != '0 && c_signf) ? c_width - L_ONE : c_width;
        c_wpm    = (c_wp > L_MAX) ? L_MAX : c_wp;
        c_dl     = LW'(i_dlen);
        c_z      = (c_zpm && c_wpm > c_dl) ? c_wpm - c_dl : '0;
        c_len1   = c_dl + c_z;
        c_apx    = r_fmt.ap && r_fmt.radix != RADIX_DEC;
        c_topz   = (c_z != '0) || (i_stat.top == 4'd0);
        c_secz   = (c_z >= L_TWO) ||
                   ((c_z == L_ONE) ? (i_stat.top == 4'd0) : (i_stat.second == 4'd0));
        c_drop   = c_apx && c_len1 > L_ONE && c_len1 == c_wp && c_topz && c_secz;

        c_len_p1 = {1'b0, r_len} + {{LW{1'b0}}, 1'b1};
        c_pfx    = r_apx && (c_len_p1 < {1'b0, L_MAX});
        c_len3   = r_len + (c_pfx ? L_TWO : '0);
        c_sgn    = c_signf && c_len3 < L_MAX;
        c_len4   = c_len3 + (c_sgn ? L_ONE : '0);
        c_wm     = (c_width > L_MAX) ? L_MAX : c_width;
        c_pad    = (c_width != '0 && c_wm > c_len4) ? c_wm - c_len4 : '0;
        c_ls     = (!r_fmt.la && !r_fmt.zp) ? c_pad : '0;
        c_ts     = r_fmt.la ? c_pad : '0;
    end

    // First non-empty section after each one.
    always_comb begin
        c_after_digit = (r_ts != '0) ? SQ_TRAIL : SQ_IDLE;
        c_after_zero  = (r_dlen != '0) ? SQ_DIGIT : c_after_digit;
        c_after_pfx1  = (r_z != '0) ? SQ_ZERO : c_after_zero;
        c_after_sign  = r_pfx ? SQ_PFX0 : c_after_pfx1;
        c_after_lead  = r_sgn ? SQ_SIGN : c_after_sign;
        c_after_trim  = (r_ls != '0) ? SQ_LEAD : c_after_lead;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SQ_IDLE:  if (i_start) n_state = SQ_WAIT;
            SQ_WAIT:  if (i_stat.ready) n_state = SQ_SIZE;
            SQ_SIZE:  n_state = SQ_TRIM;
            SQ_TRIM:  if (r_skip == 2'd0) n_state = c_after_trim;
            SQ_LEAD:  if (i_out_free && r_ls == L_ONE) n_state = c_after_lead;
            SQ_SIGN:  if (i_out_free) n_state = c_after_sign;
            SQ_PFX0:  if (i_out_free) n_state = SQ_PFX1;
            SQ_PFX1:  if (i_out_free) n_state = c_after_pfx1;
            SQ_ZERO:  if (i_out_free && r_z == L_ONE) n_state = c_after_zero;
            SQ_DIGIT: if (i_out_free && r_dlen == L_ONE) n_state = c_after_digit;
            SQ_TRAIL: if (i_out_free && r_ts == L_ONE) n_state = SQ_IDLE;
            default:  n_state = SQ_IDLE;
        endcase
    end

    always_comb begin
        c_emit      = 1'b0;
        o_char.code = CH_SPACE;
        unique case (r_state)
            SQ_LEAD, SQ_TRAIL: begin
                c_emit      = 1'b1;
                o_char.code = CH_SPACE;
            end
            SQ_SIGN: begin
                c_emit      = 1'b1;
                o_char.code = r_fmt.neg ? CH_MINUS : (r_fmt.ps ? CH_PLUS : CH_SPACE);
            end
            SQ_PFX0, SQ_ZERO: begin
                c_emit      = 1'b1;
                o_char.code = CH_ZERO;
            end
            SQ_PFX1: begin
                c_emit = 1'b1;
                unique case (r_fmt.radix)
                    RADIX_BIN:            o_char.code = CH_LB;
                    RADIX_OCT:            o_char.code = CH_LO;
                    RADIX_DEC, RADIX_HEX: o_char.code = r_fmt.uc ? CH_UX : CH_LX;
                endcase
            end
            SQ_DIGIT: begin
                c_emit      = 1'b1;
                o_char.code = digit_char(i_stat.top, r_fmt.uc);
            end
            default: begin
                c_emit = 1'b0;
            end
        endcase
        o_char.valid = c_emit && i_out_free;
        o_char.last  = (r_remain == L_ONE);
        o_cmd.load   = i_start;
        o_cmd.shift  = (r_state == SQ_TRIM && r_skip != 2'd0) ||
                       (r_state == SQ_DIGIT && i_out_free);
        o_busy       = (r_state != SQ_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (r_state == SQ_IDLE && i_start) begin
            r_fmt <= i_fmt;
        end
        if (r_state == SQ_WAIT && i_stat.ready) begin
            r_apx <= c_apx;
            if (c_drop) begin
                // Two leading zeros give way to the prefix.
                r_z    <= (c_z >= L_TWO) ? c_z - L_TWO : '0;
                r_skip <= (c_z >= L_TWO) ? 2'd0 : ((c_z == L_ONE) ? 2'd1 : 2'd2);
                r_dlen <= (c_z >= L_TWO) ? c_dl : c_dl - (L_TWO - c_z);
                r_len  <= c_len1 - L_TWO;
            end else begin
                r_z    <= c_z;
                r_skip <= 2'd0;
                r_dlen <= c_dl;
                r_len  <= c_len1;
            end
        end
        if (r_state == SQ_SIZE) begin
            r_pfx    <= c_pfx;
            r_sgn    <= c_sgn;
            r_ls     <= c_ls;
            r_ts     <= c_ts;
            r_remain <= c_ls + c_len4 + c_ts;
        end
        if (r_state == SQ_TRIM && r_skip != 2'd0) begin
            r_skip <= r_skip - 2'd1;
        end
        if (c_emit && i_out_free) begin
            r_remain <= r_remain - L_ONE;
            if (r_state == SQ_LEAD)  r_ls   <= r_ls - L_ONE;
            if (r_state == SQ_ZERO)  r_z    <= r_z - L_ONE;
            if (r_state == SQ_DIGIT) r_dlen <= r_dlen - L_ONE;
            if (r_state == SQ_TRAIL) r_ts   <= r_ts - L_ONE;
        end
    end

endmodule
